[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the battery voltage filter.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bvf_pkg.sv]
// Package for the battery voltage filter: widths, reset values, register
// indexes and the state and configuration structs. No dependencies.
`default_nettype none

package bvf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_BITS  = 16;
    localparam int CMP_BITS    = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
    localparam int COUNT_BITS  = 8;
    localparam int CFG_BITS    = 16;
    localparam int INDEX_BITS  = 2;

    localparam logic [SAMPLE_BITS-1:0] FILTER_RESET   = SAMPLE_BITS'(3628);
    localparam logic [COUNT_BITS-1:0]  LIMIT_RESET    = COUNT_BITS'(20);
    localparam logic [COUNT_BITS-1:0]  WARMUP_RESET   = COUNT_BITS'(50);
    localparam logic [FIELD_BITS-1:0]  THRESH_RESET   = '0;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX      = '1;

    localparam logic [INDEX_BITS-1:0] REG_LOW_THRESHOLD  = INDEX_BITS'(0);
    localparam logic [INDEX_BITS-1:0] REG_PERSIST_LIMIT  = INDEX_BITS'(1);
    localparam logic [INDEX_BITS-1:0] REG_WARMUP_SAMPLES = INDEX_BITS'(2);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] filter_value;
        logic [COUNT_BITS-1:0]  warmup_left;
        logic [COUNT_BITS-1:0]  low_count;
        logic                   low_flag;
    } bvf_state_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] low_threshold;
        logic [COUNT_BITS-1:0] persist_limit;
    } bvf_cfg_t;

endpackage

`default_nettype wire

[hdl/bvf_update.sv]
// Next-state logic of the battery voltage filter: warm-up count, IIR update
// with divide by ten, and the low-battery persistence counter. Uses bvf_pkg.
`default_nettype none

module bvf_update
    import bvf_pkg::*;
(
    input  bvf_state_t             cur,
    input  bvf_cfg_t               cfg,
    input  logic [SAMPLE_BITS-1:0] sample,
    output bvf_state_t             nxt
);

    // 3*s + 7*f stays below 10 * 2^S, so four extra bits hold it.
    localparam int SUM_BITS   = SAMPLE_BITS + 4;
    // Reciprocal of ten, exact for every sum below 2^SUM_BITS.
    localparam int SHIFT      = SAMPLE_BITS + 8;
    localparam int RECIP_BITS = SAMPLE_BITS + 5;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((64'd1 << SHIFT) / 64'd10 + 64'd1);

    logic [SUM_BITS-1:0]    s_ext;
    logic [SUM_BITS-1:0]    f_ext;
    logic [SUM_BITS-1:0]    sum;
    logic [PROD_BITS-1:0]   prod;
    logic [SAMPLE_BITS-1:0] filt;
    logic [CMP_BITS-1:0]    filt_cmp;
    logic [CMP_BITS-1:0]    thr_cmp;
    logic [COUNT_BITS-1:0]  warm_dec;
    logic [COUNT_BITS-1:0]  cnt_up;
    logic [COUNT_BITS-1:0]  cnt_dn;

    assign s_ext    = SUM_BITS'(sample);
    assign f_ext    = SUM_BITS'(cur.filter_value);
    assign sum      = (s_ext << 1) + s_ext + (f_ext << 3) - f_ext;
    assign prod     = PROD_BITS'(sum) * PROD_BITS'(RECIP);
    assign filt     = prod[SHIFT +: SAMPLE_BITS];
    assign filt_cmp = CMP_BITS'(filt);
    assign thr_cmp  = CMP_BITS'(cfg.low_threshold);
    assign warm_dec = cur.warmup_left - COUNT_BITS'(1);
    assign cnt_up   = (cur.low_count != COUNT_MAX) ? cur.low_count + COUNT_BITS'(1)
                                                   : cur.low_count;
    assign cnt_dn   = (cur.low_count != '0) ? cur.low_count - COUNT_BITS'(1) : '0;

    always_comb
    begin
        nxt = cur;
        if (cur.warmup_left == '0)
        begin
            nxt.filter_value = filt;
            if (filt_cmp < thr_cmp)
            begin
                if (cnt_up > cfg.persist_limit)
                begin
                    nxt.low_count = '0;
                    nxt.low_flag  = 1'b1;
                end
                else
                begin
                    nxt.low_count = cnt_up;
                end
            end
            else
            begin
                nxt.low_count = cnt_dn;
                if (cnt_dn == '0)
                begin
                    nxt.low_flag = 1'b0;
                end
            end
        end
        else
        begin
            nxt.warmup_left = warm_dec;
            // load the sample that ends the warm-up
            if (warm_dec == '0)
            begin
                nxt.filter_value = sample;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/battery_voltage_filter_low_detect.sv]
// Top level of the battery voltage filter with low-battery detection.
// Uses bvf_pkg, bvf_update and the assertion macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// One voltage sample in, one result out. A sample is registered on transfer;
// when it advances, the filter state is updated and the result (filtered
// voltage, low flag, warm-up flag) is captured in the output register from
// the same updated state. A new sample can be taken every cycle while the
// output is not stalled. The throughput of one sample per cycle is set by the
// state update loop: the IIR step (3*sample + 7*filtered, then a reciprocal
// multiply for the divide by ten), the threshold compare and the persistence
// counter all close combinationally on the state registers. The first
// warmup_samples samples only count down; the one that ends the warm-up is
// loaded as the filtered value, and until then the held value (3628 after
// reset) is reported. Configuration registers: 0 low_threshold, 1
// persist_limit, 2 warmup_samples (reloads the warm-up count only while the
// warm-up is still running). Write them only when no sample is in flight.
module battery_voltage_filter_low_detect
    import bvf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FIELD_BITS-1:0]  voltage_sample,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FIELD_BITS-1:0]  filtered_voltage,
    output logic                   battery_low,
    output logic                   warming_up
);

    // Configuration registers
    logic [FIELD_BITS-1:0]  low_threshold_reg;
    logic [COUNT_BITS-1:0]  persist_limit_reg;

    // Input stage
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    // Filter state and result register
    bvf_state_t             state_reg;
    bvf_state_t             state_next;
    bvf_cfg_t               cfg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [FIELD_BITS-1:0]  out_filt_reg;
    logic                   out_low_reg;
    logic                   out_warm_reg;

    logic                   in_xfer;
    logic                   advance;
    logic [CMP_BITS-1:0]    sample_ext;
    logic [CMP_BITS-1:0]    filt_ext;

    // Advance the input stage when the result register is free or emptying.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // Narrow or widen the sample to the filter width.
    assign sample_ext = CMP_BITS'(voltage_sample);
    assign filt_ext   = CMP_BITS'(state_next.filter_value);

    assign cfg.low_threshold = low_threshold_reg;
    assign cfg.persist_limit = persist_limit_reg;

    bvf_update u_update (
        .cur    (state_reg),
        .cfg    (cfg),
        .sample (s1_sample_reg),
        .nxt    (state_next)
    );

    // Handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the sample of the input stage until it advances.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg <= sample_ext[SAMPLE_BITS-1:0];
        end
    end

    // Configuration and filter state. The user must send writes only while idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_threshold_reg      <= THRESH_RESET;
            persist_limit_reg      <= LIMIT_RESET;
            state_reg.filter_value <= FILTER_RESET;
            state_reg.warmup_left  <= WARMUP_RESET;
            state_reg.low_count    <= '0;
            state_reg.low_flag     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LOW_THRESHOLD:
                begin
                    low_threshold_reg <= cfg_data[FIELD_BITS-1:0];
                end
                REG_PERSIST_LIMIT:
                begin
                    persist_limit_reg <= cfg_data[COUNT_BITS-1:0];
                end
                REG_WARMUP_SAMPLES:
                begin
                    // reload only while the warm-up is still running
                    if (state_reg.warmup_left != '0)
                    begin
                        state_reg.warmup_left <= cfg_data[COUNT_BITS-1:0];
                    end
                end
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: capture the updated state as the result.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_filt_reg <= filt_ext[FIELD_BITS-1:0];
            out_low_reg  <= state_next.low_flag;
            out_warm_reg <= (state_next.warmup_left != '0);
        end
    end

    assign out_valid        = out_valid_reg;
    assign filtered_voltage = out_filt_reg;
    assign battery_low      = out_low_reg;
    assign warming_up       = out_warm_reg;

    // The input stage only pushes back when it holds a sample it cannot pass on.
    `ASSERT_IMPL(a_stall_needs_item, in_stall, s1_valid_reg && out_valid_reg,
                 "input stalled without a blocked sample")
    // A sample that advances always lands in the result register.
    `ASSERT_NEXT(a_advance_gives_result, advance, out_valid_reg,
                 "advanced sample produced no result")
    // Once the warm-up has finished it never restarts.
    `ASSERT_NEXT(a_warmup_stays_done, state_reg.warmup_left == '0,
                 state_reg.warmup_left == '0, "warm-up count restarted")
    // The low flag can only be set by a running filter.
    `ASSERT_IMPL(a_low_after_warmup, state_reg.low_flag,
                 state_reg.warmup_left == '0, "low flag set during warm-up")

endmodule

`default_nettype wire
